// File: design/twcs_pkg.sv
// Shared constants, payload types and helpers for the textured wall column shader.
`default_nettype none

package twcs_pkg;

    localparam int SCREEN_LINES_DEF = 512;
    localparam int TEXTURE_DIM_DEF  = 64;

    localparam int ROW_W      = 9;
    localparam int WALL_W     = 16;
    localparam int SIDE_W     = 2;
    localparam int TADDR_W    = 12;
    localparam int COLOR_W    = 32;
    localparam int RGB_W      = 24;
    localparam int SIZE_CFG_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int NUM_BANKS  = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [SIZE_CFG_W-1:0] TEX_SIZE_RESET = SIZE_CFG_W'(64);
    localparam logic [7:0]            ALPHA_OPAQUE   = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CEILING    = 2'd0,
        CFG_FLOOR      = 2'd1,
        CFG_TEX_WIDTH  = 2'd2,
        CFG_TEX_HEIGHT = 2'd3
    } cfg_index_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_SHADE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_FLAT  = 2'd1,
        KIND_TEXEL = 2'd2
    } kind_t;

    typedef struct packed {
        logic                      operation;
        logic [ROW_W-1:0]          pixel_row;
        logic signed [WALL_W-1:0]  column_top;
        logic [WALL_W-1:0]         column_span;
        logic [WALL_W-1:0]         wall_fraction;
        logic [SIDE_W-1:0]         wall_side;
        logic [TADDR_W-1:0]        texel_address;
        logic [COLOR_W-1:0]        texel_value;
    } req_t;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
    } rsp_t;

    // One classified word handed from the front end to the shading pipeline.
    typedef struct packed {
        kind_t               kind;
        logic [SIDE_W-1:0]   bank;
        logic [TADDR_W-1:0]  offset;
        logic [COLOR_W-1:0]  word;
        logic [WALL_W-1:0]   diff;
        logic [WALL_W-1:0]   wh;
    } cmd_t;

    function automatic logic [COLOR_W-1:0] opaque(input logic [RGB_W-1:0] rgb);
        return {rgb, ALPHA_OPAQUE};
    endfunction

endpackage

`default_nettype wire

// File: design/twcs_if.sv
// Valid/ready stream interfaces for shade requests and pixel results.
`default_nettype none

interface twcs_req_if;
    import twcs_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

interface twcs_rsp_if;
    import twcs_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: design/twcs_front.sv
// Front end: takes request words and classifies them as load, flat color or texel.
`default_nettype none

module twcs_front #(
    parameter int SCREEN_LINES = twcs_pkg::SCREEN_LINES_DEF,
    parameter int TEXTURE_DIM  = twcs_pkg::TEXTURE_DIM_DEF
) (
    twcs_req_if.sink                              req,
    input  logic                                  q_ready,
    input  logic [$clog2(TEXTURE_DIM+1)-1:0]      w_used,
    input  logic [twcs_pkg::RGB_W-1:0]            ceiling_rgb,
    input  logic [twcs_pkg::RGB_W-1:0]            floor_rgb,
    output logic                                  push,
    output twcs_pkg::cmd_t                        push_data
);
    import twcs_pkg::*;

    localparam int SW         = $clog2(TEXTURE_DIM + 1);
    localparam int FPW        = WALL_W + SW;
    localparam int HALF       = SCREEN_LINES / 2;
    localparam int LAST       = SCREEN_LINES - 1;
    localparam int BANK_WORDS = TEXTURE_DIM * TEXTURE_DIM;
    localparam int EW         = $clog2(HALF + (1 << (WALL_W - 1)) + 1);

    logic [WALL_W-1:0]        wh_eff;
    logic [EW-1:0]            end_raw;
    logic [EW-1:0]            wall_end;
    logic                     floor_hit;
    logic                     ceil_hit;
    logic signed [WALL_W:0]   row_s;
    logic signed [WALL_W:0]   top_s;
    logic signed [WALL_W:0]   diff_s;
    logic [FPW-1:0]           frac_prod;
    logic [SW-1:0]            col_raw;
    logic [SW-1:0]            col;
    logic                     load_ok;
    logic                     is_load;

    always_comb
    begin
        wh_eff    = (req.payload.column_span == '0) ? WALL_W'(1) : req.payload.column_span;
        end_raw   = EW'(HALF) + EW'(req.payload.column_span >> 1);
        wall_end  = (32'(end_raw) >= SCREEN_LINES) ? EW'(LAST) : end_raw;
        floor_hit = EW'(req.payload.pixel_row) > wall_end;

        row_s    = $signed({{(WALL_W + 1 - ROW_W){1'b0}}, req.payload.pixel_row});
        top_s    = {req.payload.column_top[WALL_W-1], req.payload.column_top};
        ceil_hit = row_s < top_s;
        diff_s   = row_s - top_s;

        frac_prod = FPW'(req.payload.wall_fraction) * FPW'(w_used);
        col_raw   = frac_prod[FPW-1:WALL_W];
        col       = (col_raw >= w_used) ? (w_used - SW'(1)) : col_raw;

        is_load = (req.payload.operation == OP_LOAD);
        load_ok = 32'(req.payload.texel_address) < BANK_WORDS;

        push_data.bank = req.payload.wall_side;
        push_data.diff = diff_s[WALL_W-1:0];
        push_data.wh   = wh_eff;
        if (is_load)
        begin
            push_data.kind   = KIND_LOAD;
            push_data.offset = req.payload.texel_address;
            push_data.word   = req.payload.texel_value;
        end
        else if (floor_hit)
        begin
            push_data.kind   = KIND_FLAT;
            push_data.offset = TADDR_W'(col);
            push_data.word   = opaque(floor_rgb);
        end
        else if (ceil_hit)
        begin
            push_data.kind   = KIND_FLAT;
            push_data.offset = TADDR_W'(col);
            push_data.word   = opaque(ceiling_rgb);
        end
        else
        begin
            push_data.kind   = KIND_TEXEL;
            push_data.offset = TADDR_W'(col);
            push_data.word   = req.payload.texel_value;
        end
    end

    // A load beyond the bank is taken and dropped.
    assign req.ready = q_ready;
    assign push      = req.valid && q_ready && (!is_load || load_ok);

endmodule

`default_nettype wire

// File: design/twcs_queue.sv
// Short queue that decouples the front end from the shading pipeline.
`default_nettype none

module twcs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  twcs_pkg::cmd_t  push_data,
    output logic            ready,
    input  logic            pop,
    output logic            valid,
    output twcs_pkg::cmd_t  pop_data
);
    import twcs_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    cmd_t           entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    assign ready    = (count_reg != CW'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && ready;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: design/twcs_back.sv
// Shading pipeline: texture row divider, address stage, texture memory and result register.
`default_nettype none

module twcs_back #(
    parameter int TEXTURE_DIM = twcs_pkg::TEXTURE_DIM_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  twcs_pkg::cmd_t                    q_data,
    output logic                              q_pop,
    input  logic [$clog2(TEXTURE_DIM+1)-1:0]  w_used,
    input  logic [$clog2(TEXTURE_DIM+1)-1:0]  h_used,
    twcs_rsp_if.source                        rsp
);
    import twcs_pkg::*;

    localparam int SW         = $clog2(TEXTURE_DIM + 1);
    localparam int QW         = SW;
    localparam int NW         = WALL_W + SW;
    localparam int PW         = 2 * SW;
    localparam int BANK_WORDS = TEXTURE_DIM * TEXTURE_DIM;
    localparam int DEPTH      = NUM_BANKS * BANK_WORDS;
    localparam int AW         = $clog2(DEPTH);
    localparam int NST        = QW + 2;

    typedef struct packed {
        kind_t               kind;
        logic [SIDE_W-1:0]   bank;
        logic [TADDR_W-1:0]  offset;
        logic [COLOR_W-1:0]  word;
        logic [WALL_W-1:0]   wh;
        logic [NW-1:0]       rem;
        logic [QW-1:0]       quo;
    } stage_t;

    logic [COLOR_W-1:0]  tex_mem [DEPTH];

    logic [NST-1:0]      stg_valid_reg;
    logic [NST-1:0]      stg_valid_next;
    stage_t              stg_reg  [NST];
    stage_t              stg_next [NST];

    logic                addr_valid_reg;
    kind_t               addr_kind_reg;
    logic [AW-1:0]       addr_reg;
    logic [AW-1:0]       addr_next;
    logic [COLOR_W-1:0]  addr_word_reg;

    logic                out_valid_reg;
    logic [COLOR_W-1:0]  out_color_reg;

    logic                adv;
    logic [QW-1:0]       trow;
    logic [PW-1:0]       row_base;
    logic [NW-1:0]       sub;

    // The whole pipeline moves only when the result register is free or being taken.
    assign adv   = !out_valid_reg || rsp.ready;
    assign q_pop = adv && q_valid;

    assign rsp.valid               = out_valid_reg;
    assign rsp.payload.pixel_color = out_color_reg;

    always_comb
    begin
        stg_valid_next = {stg_valid_reg[NST-2:0], q_valid};

        stg_next[0].kind   = q_data.kind;
        stg_next[0].bank   = q_data.bank;
        stg_next[0].offset = q_data.offset;
        stg_next[0].word   = q_data.word;
        stg_next[0].wh     = q_data.wh;
        stg_next[0].rem    = (q_data.kind == KIND_TEXEL) ?
                             NW'(q_data.diff) * NW'(h_used) : '0;
        stg_next[0].quo    = '0;

        // A quotient that does not fit saturates; it is clamped below anyway.
        stg_next[1] = stg_reg[0];
        if (stg_reg[0].rem >= (NW'(stg_reg[0].wh) << QW))
        begin
            stg_next[1].rem = '0;
            stg_next[1].quo = '1;
        end

        sub = '0;
        for (int k = 0; k < QW; k++)
        begin
            stg_next[k+2] = stg_reg[k+1];
            sub = NW'(stg_reg[k+1].wh) << (QW - 1 - k);
            if (stg_reg[k+1].rem >= sub)
            begin
                stg_next[k+2].rem          = stg_reg[k+1].rem - sub;
                stg_next[k+2].quo[QW-1-k]  = 1'b1;
            end
        end

        trow     = (stg_reg[NST-1].quo >= h_used) ? (h_used - SW'(1)) : stg_reg[NST-1].quo;
        row_base = PW'(trow) * PW'(w_used);
        addr_next = AW'(stg_reg[NST-1].bank) * AW'(BANK_WORDS)
                  + ((stg_reg[NST-1].kind == KIND_TEXEL) ? AW'(row_base) : '0)
                  + AW'(stg_reg[NST-1].offset);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg  <= '0;
            addr_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            stg_valid_reg  <= stg_valid_next;
            addr_valid_reg <= stg_valid_reg[NST-1];
            out_valid_reg  <= addr_valid_reg && (addr_kind_reg != KIND_LOAD);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < NST; s++)
            begin
                stg_reg[s] <= stg_next[s];
            end
            addr_kind_reg <= stg_reg[NST-1].kind;
            addr_reg      <= addr_next;
            addr_word_reg <= stg_reg[NST-1].word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && addr_valid_reg)
        begin
            case (addr_kind_reg)
                KIND_LOAD:
                begin
                    tex_mem[addr_reg] <= addr_word_reg;
                end
                KIND_TEXEL:
                begin
                    out_color_reg <= tex_mem[addr_reg];
                end
                default:
                begin
                    out_color_reg <= addr_word_reg;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/textured_wall_column_shader.sv
// Top level of the textured wall column shader with its configuration registers.
`default_nettype none

// Takes one request word per clock while req.ready is high and returns one pixel word
// per shade request, in order; load requests write a texel into one of four banks and
// return nothing, and a load address of TEXTURE_DIM*TEXTURE_DIM or more is dropped.
// The texture row of a shade request is found by a pipelined divider with one stage
// per quotient bit, followed by an address stage and the single port texture memory
// read. A four word queue sits behind the input, so req.ready falls only while a
// finished result waits on rsp and the queue has filled. The texture memory is not
// cleared at reset; shading a texel that was never loaded gives an undefined color.
// The configuration registers may be written only while no request is in flight.
module textured_wall_column_shader #(
    parameter int SCREEN_LINES = twcs_pkg::SCREEN_LINES_DEF,
    parameter int TEXTURE_DIM  = twcs_pkg::TEXTURE_DIM_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    twcs_req_if.sink                            req,
    twcs_rsp_if.source                          rsp,
    input  logic                                cfg_we,
    input  logic [twcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [twcs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import twcs_pkg::*;

    localparam int SW = $clog2(TEXTURE_DIM + 1);

    logic [RGB_W-1:0]       ceiling_rgb_reg;
    logic [RGB_W-1:0]       floor_rgb_reg;
    logic [SIZE_CFG_W-1:0]  tex_width_reg;
    logic [SIZE_CFG_W-1:0]  tex_height_reg;
    logic [SW-1:0]          w_used;
    logic [SW-1:0]          h_used;

    logic                   push;
    cmd_t                   push_data;
    logic                   q_ready;
    logic                   q_valid;
    logic                   q_pop;
    cmd_t                   q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceiling_rgb_reg <= '0;
            floor_rgb_reg   <= '0;
            tex_width_reg   <= TEX_SIZE_RESET;
            tex_height_reg  <= TEX_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_CEILING:    ceiling_rgb_reg <= cfg_data[RGB_W-1:0];
                CFG_FLOOR:      floor_rgb_reg   <= cfg_data[RGB_W-1:0];
                CFG_TEX_WIDTH:  tex_width_reg   <= cfg_data[SIZE_CFG_W-1:0];
                CFG_TEX_HEIGHT: tex_height_reg  <= cfg_data[SIZE_CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    // A size of zero is used as one and a size beyond the texture as the full texture.
    always_comb
    begin
        if (tex_width_reg == '0)
        begin
            w_used = SW'(1);
        end
        else if (32'(tex_width_reg) > TEXTURE_DIM)
        begin
            w_used = SW'(TEXTURE_DIM);
        end
        else
        begin
            w_used = SW'(tex_width_reg);
        end

        if (tex_height_reg == '0)
        begin
            h_used = SW'(1);
        end
        else if (32'(tex_height_reg) > TEXTURE_DIM)
        begin
            h_used = SW'(TEXTURE_DIM);
        end
        else
        begin
            h_used = SW'(tex_height_reg);
        end
    end

    twcs_front #(
        .SCREEN_LINES (SCREEN_LINES),
        .TEXTURE_DIM  (TEXTURE_DIM)
    ) u_front (
        .req         (req),
        .q_ready     (q_ready),
        .w_used      (w_used),
        .ceiling_rgb (ceiling_rgb_reg),
        .floor_rgb   (floor_rgb_reg),
        .push        (push),
        .push_data   (push_data)
    );

    twcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_data)
    );

    twcs_back #(
        .TEXTURE_DIM (TEXTURE_DIM)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .w_used  (w_used),
        .h_used  (h_used),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

// File: design/twcs_checker.sv
// Port-level checker for the textured wall column shader and its bind statement.
`default_nettype none

module twcs_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  logic                          req_operation,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  logic [twcs_pkg::COLOR_W-1:0]  rsp_pixel_color
);
    import twcs_pkg::*;

    logic [7:0] pending_reg;
    logic [7:0] pending_next;

    // Shade words taken whose pixel word has not yet been delivered.
    always_comb
    begin
        pending_next = pending_reg;
        if (req_valid && req_ready && (req_operation == OP_SHADE))
        begin
            pending_next = pending_next + 8'd1;
        end
        if (rsp_valid && rsp_ready)
        begin
            pending_next = pending_next - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("pixel word offered during reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_color))
        else $error("stalled pixel word changed or vanished");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 8'd0)
        else $error("pixel word without an outstanding shade request");

    assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("input stalled while no pixel word is waiting");

endmodule

bind textured_wall_column_shader twcs_checker u_twcs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_operation   (req.payload.operation),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_pixel_color (rsp.payload.pixel_color)
);

`default_nettype wire
